// ----- design/cpws_pkg.sv -----
// Package for the capture-period wheel speed unit.
// Holds the sizing constants, register indexes and the ring access type.
// Used by every module under design/.
package cpws_pkg;

  // Captures per batch and batches in the moving average.
  localparam int unsigned BatchLen = 16;
  localparam int unsigned AvgLen   = 8;

  // Field widths.
  localparam int unsigned CAPTURE_W = 32;
  localparam int unsigned SPEED_W   = 32;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned TOTAL_W   = 38;

  // Fixed scale applied to the numerator: captures * batches * 2^8.
  localparam int unsigned Scale   = BatchLen * AvgLen * 256;
  localparam int unsigned SCALE_W = $clog2(Scale + 1);
  localparam int unsigned NUM_W   = CAPTURE_W + SCALE_W;

  // Counter and index widths.
  localparam int unsigned RING_AW  = (AvgLen > 1) ? $clog2(AvgLen) : 1;
  localparam int unsigned BCNT_W   = $clog2(BatchLen + 1);
  localparam int unsigned DIVCNT_W = $clog2(NUM_W + 1);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'b1;

  // Register values after reset.
  localparam logic [CAPTURE_W-1:0] NUMERATOR_RESET = 32'd1222471910;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd100;

  // One access to the ring memory.
  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic [RING_AW-1:0]   addr;
    logic [CAPTURE_W-1:0] wdata;
  } ring_req_t;

endpackage

// ----- design/cpws_ring.sv -----
// Ring of batch sums held in a synchronous memory with a registered read.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on cpws_pkg.
module cpws_ring (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cpws_pkg::ring_req_t        req_i,
  output logic [cpws_pkg::CAPTURE_W-1:0] rdata_o
);
  import cpws_pkg::*;

  logic [CAPTURE_W-1:0] mem [AvgLen];
  logic [CAPTURE_W-1:0] rd_data_q;
  logic [AvgLen-1:0]    valid_q;
  logic                 rd_valid_q;

  // Memory array: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rd_data_q <= mem[req_i.addr];
    end
  end

  // Valid bits stand in for clearing the memory at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd) begin
        rd_valid_q <= valid_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- design/cpws_divider.sv -----
// Restoring serial divider, one quotient bit per cycle, with saturation to 32 bits.
// A zero divisor yields an all-ones quotient and so saturates.
// Depends on cpws_pkg.
module cpws_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cpws_pkg::NUM_W-1:0]   dividend_i,
  input  logic [cpws_pkg::TOTAL_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [cpws_pkg::SPEED_W-1:0] quotient_o
);
  import cpws_pkg::*;

  logic [NUM_W-1:0]    dvd_q, dvd_d;
  logic [TOTAL_W-1:0]  den_q, den_d;
  logic [TOTAL_W-1:0]  rem_q, rem_d;
  logic [DIVCNT_W-1:0] cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [TOTAL_W:0]    rem_sh;
  logic                fits;

  // One restoring step: shift in the next dividend bit and trial-subtract.
  assign rem_sh = {rem_q, dvd_q[NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});

  always_comb begin
    dvd_d  = dvd_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      den_d = divisor_i;
      rem_d = '0;
      cnt_d = DIVCNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? TOTAL_W'(rem_sh - {1'b0, den_q}) : rem_sh[TOTAL_W-1:0];
      dvd_d  = {dvd_q[NUM_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIVCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  // The shift register holds the quotient once the count runs out.
  assign done_o     = done_q;
  assign quotient_o = (|dvd_q[NUM_W-1:SPEED_W]) ? '1 : dvd_q[SPEED_W-1:0];

endmodule

// ----- design/capture_period_wheel_speed_unit.sv -----
// Wheel speed from timer captures. A millisecond tick, or a capture that does not complete a
// batch, is handled in the idle state. The capture that completes a batch of 16 reads the old
// ring entry at its accepting edge and writes the new one in the next cycle. The divider is then
// started and runs NUM_W = 48 division steps; the controller sees it finish and then loads the
// output register. No input is taken until that speed item is loaded. The ring is cleared by
// per-entry valid bits, so no clearing pass follows reset. A finished item waits in the output
// register, and the input is held off while it waits unless the receiver takes it in the same
// cycle. Depends on cpws_pkg, cpws_ring and cpws_divider.
module capture_period_wheel_speed_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [cpws_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cpws_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Input items.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [cpws_pkg::CAPTURE_W-1:0]   s_axis_tdata_i,   // [31:0] capture_time
  input  logic                             s_axis_tuser_i,   // [0] func
  // Result items.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [cpws_pkg::SPEED_W-1:0]     m_axis_tdata_o,   // [31:0] speed
  output logic                             m_axis_tuser_o    // [0] timed_out
);
  import cpws_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RMW   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [CAPTURE_W-1:0] numerator_q;
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [CAPTURE_W-1:0] prev_q, prev_d;
  logic [CAPTURE_W-1:0] bsum_q, bsum_d;
  logic [BCNT_W-1:0]    bcnt_q, bcnt_d;
  logic [RING_AW-1:0]   pos_q, pos_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [TIMEOUT_W-1:0] elapsed_q, elapsed_d;
  logic                 stale_q, stale_d;
  logic [CAPTURE_W-1:0] pend_q, pend_d;
  logic [NUM_W-1:0]     prod_q, prod_d;
  logic                 out_valid_q, out_valid_d;
  logic [SPEED_W-1:0]   out_speed_q, out_speed_d;
  logic                 out_timed_q, out_timed_d;

  logic                 accept;
  logic                 out_free;
  logic [CAPTURE_W-1:0] bsum_next;
  logic [BCNT_W-1:0]    bcnt_next;
  logic [TIMEOUT_W-1:0] elapsed_inc;
  ring_req_t            ring_req;
  logic [CAPTURE_W-1:0] ring_old;
  logic                 div_start;
  logic                 div_done;
  logic [SPEED_W-1:0]   div_quot;

  // Ring memory and divider.
  cpws_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ring_req),
    .rdata_o (ring_old)
  );

  cpws_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Handshake: the output register frees up in the same cycle it is taken.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign bsum_next   = bsum_q + (s_axis_tdata_i - prev_q);
  assign bcnt_next   = bcnt_q + 1'b1;
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign div_start   = (state_q == ST_START);

  // Main control: capture and tick handling, ring update and result hand-off.
  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    bsum_d      = bsum_q;
    bcnt_d      = bcnt_q;
    pos_d       = pos_q;
    total_d     = total_q;
    elapsed_d   = elapsed_q;
    stale_d     = stale_q;
    pend_d      = pend_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_speed_d = out_speed_q;
    out_timed_d = out_timed_q;
    ring_req    = '0;
    ring_req.addr  = pos_q;
    ring_req.wdata = pend_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && s_axis_tuser_i) begin
          // Millisecond tick.
          elapsed_d = elapsed_inc;
          if ((elapsed_inc >= timeout_q) && !stale_q) begin
            stale_d     = 1'b1;
            out_valid_d = 1'b1;
            out_speed_d = '0;
            out_timed_d = 1'b1;
          end
        end else if (accept) begin
          // Capture timestamp.
          prev_d = s_axis_tdata_i;
          if (bcnt_next == BCNT_W'(BatchLen)) begin
            pend_d      = bsum_next;
            prod_d      = NUM_W'({{SCALE_W{1'b0}}, numerator_q} * NUM_W'(Scale));
            bsum_d      = '0;
            bcnt_d      = '0;
            elapsed_d   = '0;
            stale_d     = 1'b0;
            ring_req.rd = 1'b1;
            state_d     = ST_RMW;
          end else begin
            bsum_d = bsum_next;
            bcnt_d = bcnt_next;
          end
        end
      end
      ST_RMW: begin
        // Old entry is out of the memory now: replace it and fix up the total.
        ring_req.wr = 1'b1;
        total_d     = total_q - TOTAL_W'(ring_old) + TOTAL_W'(pend_q);
        pos_d       = (pos_q == RING_AW'(AvgLen - 1)) ? '0 : pos_q + 1'b1;
        state_d     = ST_START;
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_speed_d = div_quot;
          out_timed_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numerator_q <= NUMERATOR_RESET;
      timeout_q   <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_NUMERATOR: numerator_q <= cfg_data_i;
        CFG_TIMEOUT:   timeout_q   <= cfg_data_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Measurement state and control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      bsum_q      <= '0;
      bcnt_q      <= '0;
      pos_q       <= '0;
      total_q     <= '0;
      elapsed_q   <= '0;
      stale_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      bsum_q      <= bsum_d;
      bcnt_q      <= bcnt_d;
      pos_q       <= pos_d;
      total_q     <= total_d;
      elapsed_q   <= elapsed_d;
      stale_q     <= stale_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_q      <= pend_d;
    prod_q      <= prod_d;
    out_speed_q <= out_speed_d;
    out_timed_q <= out_timed_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_speed_q;
  assign m_axis_tuser_o  = out_timed_q;

`ifndef SYNTHESIS
  // A timeout item always carries a speed of zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_timed_q) |-> (out_speed_q == '0))
    else $error("timeout item with non-zero speed");

  // Every ring write follows a read of the same entry in the previous cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_req.wr |-> ($past(ring_req.rd) && ($past(ring_req.addr) == ring_req.addr)))
    else $error("ring write without a preceding read");

  // The divider finishes only while the controller waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider done outside the divide state");

  // The ring update is always followed by the start of the division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW) |=> (state_q == ST_START))
    else $error("ring update not followed by divider start");
`endif

endmodule

// ----- verif/tb_capture_period_wheel_speed_unit.sv -----
// Self-checking testbench for capture_period_wheel_speed_unit: drives capture and tick items,
// predicts every speed item and compares it with what the block emits.
// Depends on cpws_pkg and the design files under design/.
module tb_capture_period_wheel_speed_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cpws_pkg::*;

  localparam int unsigned CLK_PERIOD        = 10;
  localparam int unsigned RESET_CYCLES      = 7;
  // Wait after the last expected speed item before a register write.
  localparam int unsigned SETTLE_CYCLES     = 64;
  localparam int unsigned HOLD_OFF_CYCLES   = 400;
  // A long output hold plus a full division, taken several times over.
  localparam int unsigned STALL_LIMIT       = 3000;
  localparam int unsigned PHASE_ITEMS       = 115;
  localparam int unsigned HOLD_AT_ITEM      = 60;
  localparam int unsigned DRAIN_AT_ITEM     = 40;
  localparam int unsigned MAX_REPORTS       = 10;
  localparam int unsigned PLAN_ROWS         = 19;

  typedef enum logic {FN_CAPTURE = 1'b0, FN_TICK = 1'b1} func_e;
  typedef enum logic {ROW_WRITE = 1'b0, ROW_ITEM = 1'b1} row_kind_e;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               timed_out;
  } speed_result_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    func_e                 func;
    logic [CFG_DATA_W-1:0] value;
    logic [4:0]            copies;
    logic                  has_expected;
    speed_result_t         expected;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [CAPTURE_W-1:0]  s_axis_tdata_i;   // [31:0] capture_time
  logic                  s_axis_tuser_i;   // [0] func
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [SPEED_W-1:0]    m_axis_tdata_o;   // [31:0] speed
  logic                  m_axis_tuser_o;   // [0] timed_out

  // Speed predictor state and its copy of the registers.
  logic [CAPTURE_W-1:0] last_capture;
  logic [CAPTURE_W-1:0] gap_sum;
  logic [7:0]           gaps_in_batch;
  logic [CAPTURE_W-1:0] batch_ring [AvgLen];
  int unsigned          ring_slot;
  logic [TOTAL_W-1:0]   ring_sum;
  logic [TIMEOUT_W-1:0] ms_since_batch;
  logic                 timeout_sent;
  logic [CAPTURE_W-1:0] numerator_reg;
  logic [TIMEOUT_W-1:0] timeout_reg;

  speed_result_t pending_speeds [$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  logic        hold_go;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned speeds_checked;
  int unsigned timeouts_checked;

  // Directed plan: register writes and runs of identical items. Expected values are typed in
  // only where they are obvious; the other rows go through the predictor.
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{ROW_WRITE, CFG_TIMEOUT,   FN_CAPTURE, 32'd1,          5'd0,  1'b0, '{32'd0, 1'b0}},
    // Ticks before any batch time out once, then stay quiet.
    '{ROW_ITEM,  CFG_NUMERATOR, FN_TICK,    32'd0,          5'd1,  1'b1, '{32'd0, 1'b1}},
    '{ROW_ITEM,  CFG_NUMERATOR, FN_TICK,    32'd0,          5'd1,  1'b0, '{32'd0, 1'b0}},
    // A batch of zero gaps leaves a zero total, so the speed is full scale.
    '{ROW_ITEM,  CFG_NUMERATOR, FN_CAPTURE, 32'd0,          5'd16, 1'b1,
      '{32'hFFFF_FFFF, 1'b0}},
    '{ROW_ITEM,  CFG_NUMERATOR, FN_TICK,    32'd0,          5'd1,  1'b1, '{32'd0, 1'b1}},
    // A total of one saturates the quotient.
    '{ROW_ITEM,  CFG_NUMERATOR, FN_CAPTURE, 32'd0,          5'd15, 1'b0, '{32'd0, 1'b0}},
    '{ROW_ITEM,  CFG_NUMERATOR, FN_CAPTURE, 32'd1,          5'd1,  1'b1,
      '{32'hFFFF_FFFF, 1'b0}},
    '{ROW_WRITE, CFG_NUMERATOR, FN_CAPTURE, 32'd0,          5'd0,  1'b0, '{32'd0, 1'b0}},
    '{ROW_ITEM,  CFG_NUMERATOR, FN_CAPTURE, 32'd1,          5'd16, 1'b1, '{32'd0, 1'b0}},
    '{ROW_WRITE, CFG_NUMERATOR, FN_CAPTURE, 32'hFFFF_FFFF,  5'd0,  1'b0, '{32'd0, 1'b0}},
    '{ROW_WRITE, CFG_TIMEOUT,   FN_CAPTURE, 32'h0000_FFFF,  5'd0,  1'b0, '{32'd0, 1'b0}},
    // The total becomes exactly the numerator, leaving only the fixed scale.
    '{ROW_ITEM,  CFG_NUMERATOR, FN_CAPTURE, 32'hFFFF_FFFF,  5'd16, 1'b1,
      '{32'd32768, 1'b0}},
    '{ROW_ITEM,  CFG_NUMERATOR, FN_CAPTURE, 32'hAAAA_AAAA,  5'd1,  1'b0, '{32'd0, 1'b0}},
    '{ROW_ITEM,  CFG_NUMERATOR, FN_CAPTURE, 32'h5555_5555,  5'd15, 1'b0, '{32'd0, 1'b0}},
    '{ROW_ITEM,  CFG_NUMERATOR, FN_TICK,    32'hFFFF_FFFF,  5'd3,  1'b0, '{32'd0, 1'b0}},
    // A timeout of zero fires on the first tick after a batch.
    '{ROW_WRITE, CFG_TIMEOUT,   FN_CAPTURE, 32'd0,          5'd0,  1'b0, '{32'd0, 1'b0}},
    '{ROW_ITEM,  CFG_NUMERATOR, FN_TICK,    32'd0,          5'd1,  1'b0, '{32'd0, 1'b0}},
    '{ROW_ITEM,  CFG_NUMERATOR, FN_CAPTURE, 32'h1234_5678,  5'd16, 1'b0, '{32'd0, 1'b0}},
    '{ROW_ITEM,  CFG_NUMERATOR, FN_TICK,    32'd0,          5'd1,  1'b0, '{32'd0, 1'b0}}
  };

  capture_period_wheel_speed_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Advances the predictor by one accepted item; returns 1 when a speed item results.
  function automatic logic predict_speed(input func_e func, input logic [CAPTURE_W-1:0] cap,
                                         output speed_result_t res);
    logic [63:0] scaled;
    logic [63:0] quot;
    res = '0;
    if (func == FN_TICK) begin
      if (ms_since_batch != '1) ms_since_batch++;
      if (ms_since_batch >= timeout_reg && !timeout_sent) begin
        timeout_sent  = 1'b1;
        res.timed_out = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    // Gaps wrap at 32 bits, and so does their sum.
    gap_sum      = gap_sum + (cap - last_capture);
    last_capture = cap;
    gaps_in_batch++;
    if (gaps_in_batch < BatchLen) return 1'b0;
    ring_sum = ring_sum - TOTAL_W'(batch_ring[ring_slot]) + TOTAL_W'(gap_sum);
    batch_ring[ring_slot] = gap_sum;
    ring_slot      = (ring_slot + 1) % AvgLen;
    gap_sum        = '0;
    gaps_in_batch  = '0;
    ms_since_batch = '0;
    timeout_sent   = 1'b0;
    if (ring_sum == '0) begin
      res.speed = '1;
    end else begin
      scaled    = 64'(numerator_reg) * 64'(BatchLen * AvgLen * 256);
      quot      = scaled / 64'(ring_sum);
      res.speed = (quot > 64'h0000_0000_FFFF_FFFF) ? '1 : quot[SPEED_W-1:0];
    end
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string what, input logic [SPEED_W-1:0] want,
                                        input logic [SPEED_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
  endfunction

  // Offers one item, waits for it to be taken and records the speed item it causes.
  // The valid stays high afterwards so that back-to-back items need no bubble.
  task automatic send_item(input func_e func, input logic [CAPTURE_W-1:0] cap,
                           input logic typed_valid, input speed_result_t typed);
    speed_result_t res;
    logic          produced;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= cap;
    s_axis_tuser_i  <= func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    produced = predict_speed(func, cap, res);
    if (produced) pending_speeds.push_back(typed_valid ? typed : res);
  endtask

  // Stops offering items and waits until the block has nothing left to deliver.
  task automatic wait_until_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_until_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_NUMERATOR: numerator_reg = val;
      CFG_TIMEOUT:   timeout_reg   = val[TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  // Result side: check each accepted speed item and drive tready, with a single long hold.
  always @(posedge clk_i) begin : speed_sink
    speed_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      speeds_checked++;
      if (m_axis_tuser_o) timeouts_checked++;
      if (pending_speeds.size() == 0) begin
        note_mismatch("speed item with nothing pending", '0, m_axis_tdata_o);
      end else begin
        want = pending_speeds.pop_front();
        if (m_axis_tdata_o !== want.speed) note_mismatch("speed", want.speed, m_axis_tdata_o);
        if (m_axis_tuser_o !== want.timed_out)
          note_mismatch("timed_out", SPEED_W'(want.timed_out), SPEED_W'(m_axis_tuser_o));
      end
    end
    if (hold_go) hold_left = HOLD_OFF_CYCLES;
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: ends the run if neither side moves an item for too long.
  always @(posedge clk_i) begin : stall_watch
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        cfg_we_i || !rst_ni)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles without an item moving", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CAPTURE_W-1:0] period;
    int unsigned          pick;
    int unsigned          burst;
    int unsigned          count;
    logic                 hold_done;
    logic                 drain_done;

    // Known values on every input from time zero; predictor follows the reset state.
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_NUMERATOR;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = FN_CAPTURE;
    m_axis_tready_i = 1'b0;
    hold_go         = 1'b0;
    hold_left       = 0;
    quiet_cycles    = 0;
    mismatches      = 0;
    items_sent      = 0;
    speeds_checked  = 0;
    timeouts_checked = 0;
    src_idle_pct    = 6;
    sink_idle_pct   = 58;
    period          = 32'd1000;
    hold_done       = 1'b0;
    drain_done      = 1'b0;
    last_capture    = '0;
    gap_sum         = '0;
    gaps_in_batch   = '0;
    foreach (batch_ring[i]) batch_ring[i] = '0;
    ring_slot       = 0;
    ring_sum        = '0;
    ms_since_batch  = '0;
    timeout_sent    = 1'b0;
    numerator_reg   = NUMERATOR_RESET;
    timeout_reg     = TIMEOUT_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_WRITE) begin
        write_reg(directed_plan[r].reg_index, directed_plan[r].value);
      end else begin
        for (int c = 0; c < directed_plan[r].copies; c++)
          send_item(directed_plan[r].func, directed_plan[r].value,
                    directed_plan[r].has_expected, directed_plan[r].expected);
      end
    end

    // Random part in three handshake phases, each with its own register settings.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 6;
          sink_idle_pct = 58;
          write_reg(CFG_NUMERATOR, $urandom);
          write_reg(CFG_TIMEOUT, $urandom_range(2, 12));
        end
        1: begin
          src_idle_pct  = 58;
          sink_idle_pct = 6;
          write_reg(CFG_NUMERATOR, NUMERATOR_RESET);
          write_reg(CFG_TIMEOUT, $urandom_range(16, 48));
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
          write_reg(CFG_NUMERATOR, $urandom_range(1, 32'h0000_FFFF));
          write_reg(CFG_TIMEOUT, TIMEOUT_RESET);
        end
      endcase
      count = 0;
      while (count < PHASE_ITEMS) begin
        // Hold the output long enough for the block to fill and stall its input.
        if (ph == 0 && !hold_done && count >= HOLD_AT_ITEM) begin
          hold_done       = 1'b1;
          s_axis_tvalid_i <= 1'b0;
          hold_go         <= 1'b1;
          @(posedge clk_i);
          hold_go <= 1'b0;
        end
        // Pause the sender until every expected item has come out.
        if (ph == 1 && !drain_done && count >= DRAIN_AT_ITEM) begin
          drain_done = 1'b1;
          wait_until_idle();
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
          // Well-formed wheel: a steady period per batch with a little jitter, sometimes
          // a huge one so that the timer wraps.
          if (gaps_in_batch == 0)
            period = ($urandom_range(19) == 0) ? $urandom : $urandom_range(500, 200000);
          send_item(FN_CAPTURE, last_capture + period + $urandom_range(0, 63), 1'b0, '0);
          count++;
        end else if (pick < 80) begin
          send_item(FN_CAPTURE, $urandom, 1'b0, '0);
          count++;
        end else if (pick < 98) begin
          send_item(FN_TICK, $urandom, 1'b0, '0);
          count++;
        end else begin
          // A run of ticks long enough to reach the timeout.
          burst = timeout_reg + $urandom_range(0, 3);
          for (int k = 0; k < burst; k++) begin
            send_item(FN_TICK, $urandom, 1'b0, '0);
            count++;
          end
        end
      end
    end

    wait_until_idle();
    if (pending_speeds.size() != 0) begin
      $display("%0d speed items never arrived", pending_speeds.size());
      mismatches += pending_speeds.size();
    end
    $display("Sent %0d items and checked %0d speed items, %0d of them timeouts.",
             items_sent, speeds_checked, timeouts_checked);
    $display("Three stall mixes, register extremes, zero and saturated speeds, long output hold.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
